/* sv/dhas_pkg.sv */
// shared widths, constants and register codes for the 2x2 hole-aware depth smoother
`timescale 1ns / 1ps

package dhas_pkg;

  localparam int DEPTH_W = 16;  // depth sample width
  localparam int ROW_W   = 11;  // out_row width
  localparam int COL_W   = 10;  // out_col width
  localparam int FW_W    = 11;  // frame_width register width
  localparam int FH_W    = 12;  // frame_height register width
  localparam int CFG_W   = 12;  // widest register
  localparam int SUM_W   = 18;  // sum of four depth samples
  localparam int CNT_W   = 3;   // count of nonzero samples, 0..4

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

  // floor(s/3) = (s * DIV3_MULT) >> DIV3_SHIFT for every s below 2^19
  localparam int DIV3_MULT_W = 20;
  localparam logic [DIV3_MULT_W-1:0] DIV3_MULT = DIV3_MULT_W'(699051);
  localparam int DIV3_SHIFT = 21;
  localparam int PROD_W = SUM_W + DIV3_MULT_W;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  // result slots of one input pixel, in emission order
  typedef enum logic [1:0] {
    SLOT_UPPER_LEFT  = 2'd0,  // (r-1, c-1), full 2x2 window
    SLOT_UPPER_EDGE  = 2'd1,  // (r-1, c) on the last column
    SLOT_LOWER_LEFT  = 2'd2,  // (r, c-1) on the last row
    SLOT_LOWER_EDGE  = 2'd3   // (r, c) bottom-right corner
  } slot_t;

  typedef logic [DEPTH_W-1:0] depth_t;

endpackage

/* sv/dhas_if.sv */
// stream interfaces for depth pixels in and smoothed results out
`timescale 1ns / 1ps

interface dhas_pix_if;
  import dhas_pkg::*;

  logic   valid;
  logic   ready;
  depth_t pixel_depth;

  modport source (output valid, output pixel_depth, input ready);
  modport sink   (input valid, input pixel_depth, output ready);
endinterface

interface dhas_res_if;
  import dhas_pkg::*;

  logic             valid;
  logic             ready;
  depth_t           smoothed_depth;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic             last_of_item;
  logic             end_of_frame;

  modport source (output valid, output smoothed_depth, output out_row, output out_col,
                  output last_of_item, output end_of_frame, input ready);
  modport sink   (input valid, input smoothed_depth, input out_row, input out_col,
                  input last_of_item, input end_of_frame, output ready);
endinterface

/* sv/depth_hole_aware_smooth_2x2.sv */
// top level: 2x2 hole-aware depth smoother with one line store of the previous row
`timescale 1ns / 1ps

//  channel | dir | handshake         | payload
//  --------+-----+-------------------+----------------------------------------------
//  pix     | in  | valid / ready     | pixel_depth
//  res     | out | valid / ready     | smoothed_depth, out_row, out_col,
//          |     |                   | last_of_item, end_of_frame
//  cfg     | in  | cfg_we, no ready  | cfg_index, cfg_data
//
//  an item with n results (0..4) goes through the line store read step, then per
//  result a step to sum the window and a step to divide. the shared mean unit serves
//  one result at a time, so the next item is accepted only once this item is done.
//  rst is synchronous; it sets 640 x 480 and restarts at (0,0). the line store
//  is not cleared; row 0 fills it before any later row reads it.
//  a stalled res only holds the divide step; the last result of an item waits
//  in the output register while the next item is accepted.

module depth_hole_aware_smooth_2x2 #(
  parameter int MAX_WIDTH  = dhas_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dhas_pkg::MAX_HEIGHT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  dhas_pkg::reg_index_t       cfg_index,
  input  logic [dhas_pkg::CFG_W-1:0] cfg_data,
  dhas_pix_if.sink                   pix,
  dhas_res_if.source                 res
);
  import dhas_pkg::*;

  // position widths follow the maximum frame size
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int WCMP = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;
  localparam int HCMP = ($clog2(MAX_HEIGHT + 1) > FH_W) ? $clog2(MAX_HEIGHT + 1) : FH_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,  // waiting for a pixel
    S_READ = 4'b0010,  // line store data arrives, write back current pixel
    S_SUM  = 4'b0100,  // load the mean unit for the next slot
    S_DIV  = 4'b1000   // divide result into the output register
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;

  // frame position and the left-hand pixels of the 2x2 window
  logic [CW-1:0] col_pos;
  logic [RW-1:0] row_pos;
  depth_t        left_pixel;
  depth_t        upper_left_pixel;

  // captured per item
  depth_t        cur_q;
  depth_t        left_q;
  depth_t        ul_q;
  depth_t        up_q;
  logic [CW-1:0] c_q;
  logic [RW-1:0] r_q;
  logic          lc_q;
  logic [3:0]    slot_mask;
  slot_t         slot_q;

  // effective frame size: zero reads as one, clamp to the maximum
  logic [WCMP-1:0] w_ext, w_eff;
  logic [HCMP-1:0] h_ext, h_eff;
  logic [CW-1:0]   w_last, c_eff;
  logic [RW-1:0]   h_last, r_eff;
  logic            last_col, last_row;
  logic            accept;
  logic [3:0]      mask_new;

  always_comb begin
    w_ext = WCMP'(frame_width);
    h_ext = HCMP'(frame_height);
    if (w_ext == '0) begin
      w_eff = WCMP'(1);
    end else if (w_ext > WCMP'(MAX_WIDTH)) begin
      w_eff = WCMP'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (h_ext == '0) begin
      h_eff = HCMP'(1);
    end else if (h_ext > HCMP'(MAX_HEIGHT)) begin
      h_eff = HCMP'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
  end

  assign w_last   = CW'(w_eff - WCMP'(1));
  assign h_last   = RW'(h_eff - HCMP'(1));
  // a position at or past the edge is treated as the edge
  assign last_col = (col_pos >= w_last);
  assign last_row = (row_pos >= h_last);
  assign c_eff    = last_col ? w_last : col_pos;
  assign r_eff    = last_row ? h_last : row_pos;

  assign pix.ready = (state == S_IDLE);
  assign accept    = pix.valid && pix.ready;

  // which of the four result slots this pixel finishes
  assign mask_new[SLOT_UPPER_LEFT] = (r_eff != '0) && (c_eff != '0);
  assign mask_new[SLOT_UPPER_EDGE] = (r_eff != '0) && last_col;
  assign mask_new[SLOT_LOWER_LEFT] = last_row && (c_eff != '0);
  assign mask_new[SLOT_LOWER_EDGE] = last_row && last_col;

  // line store: read at accept, write back the current pixel in the next cycle (S_READ)
  depth_t ram_rdata;

  dhas_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (state == S_READ),
    .waddr (c_q),
    .wdata (cur_q),
    .raddr (c_eff),
    .rdata (ram_rdata)
  );

  // lowest pending slot
  slot_t      slot_pick;
  logic [3:0] mask_rest;

  always_comb begin
    priority if (slot_mask[SLOT_UPPER_LEFT]) begin
      slot_pick = SLOT_UPPER_LEFT;
    end else if (slot_mask[SLOT_UPPER_EDGE]) begin
      slot_pick = SLOT_UPPER_EDGE;
    end else if (slot_mask[SLOT_LOWER_LEFT]) begin
      slot_pick = SLOT_LOWER_LEFT;
    end else begin
      slot_pick = SLOT_LOWER_EDGE;
    end
  end

  assign mask_rest = slot_mask & ~(4'b0001 << slot_q);

  // window operands per slot, absent neighbours as zero
  depth_t [3:0] mean_vals;
  depth_t       mean_out;

  always_comb begin
    mean_vals = '0;
    unique case (slot_pick)
      SLOT_UPPER_LEFT: mean_vals = {ul_q, up_q, left_q, cur_q};
      SLOT_UPPER_EDGE: mean_vals = {up_q, cur_q, DEPTH_W'(0), DEPTH_W'(0)};
      SLOT_LOWER_LEFT: mean_vals = {left_q, cur_q, DEPTH_W'(0), DEPTH_W'(0)};
      SLOT_LOWER_EDGE: mean_vals = {cur_q, DEPTH_W'(0), DEPTH_W'(0), DEPTH_W'(0)};
      default:         mean_vals = '0;
    endcase
  end

  dhas_mean u_mean (
    .clk  (clk),
    .load (state == S_SUM),
    .vals (mean_vals),
    .mean (mean_out)
  );

  // output register loads when empty or being drained
  logic out_load;
  assign out_load = (state == S_DIV) && (!res.valid || res.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_READ;
      S_READ: state_next = (slot_mask == '0) ? S_IDLE : S_SUM;
      S_SUM:  state_next = S_DIV;
      S_DIV: begin
        if (out_load) begin
          state_next = (mask_rest == '0) ? S_IDLE : S_SUM;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      frame_width      <= FRAME_WIDTH_RST;
      frame_height     <= FRAME_HEIGHT_RST;
      col_pos          <= '0;
      row_pos          <= '0;
      left_pixel       <= '0;
      upper_left_pixel <= '0;
      slot_mask        <= '0;
      res.valid        <= 1'b0;
    end else begin
      state <= state_next;

      // register write restarts the frame
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
          REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
          default: ;
        endcase
        col_pos          <= '0;
        row_pos          <= '0;
        left_pixel       <= '0;
        upper_left_pixel <= '0;
      end else if (accept) begin
        if (last_col) begin
          col_pos <= '0;
          row_pos <= last_row ? '0 : RW'(r_eff + RW'(1));
        end else begin
          col_pos <= CW'(c_eff + CW'(1));
          row_pos <= r_eff;
        end
      end else if (state == S_READ) begin
        left_pixel       <= lc_q ? '0 : cur_q;
        upper_left_pixel <= lc_q ? '0 : ram_rdata;
      end

      if (accept) begin
        slot_mask <= mask_new;
      end else if (out_load) begin
        slot_mask <= mask_rest;
      end

      if (out_load) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // item and result payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_q  <= pix.pixel_depth;
      left_q <= left_pixel;
      ul_q   <= upper_left_pixel;
      c_q    <= c_eff;
      r_q    <= r_eff;
      lc_q   <= last_col;
    end
    if (state == S_READ) begin
      up_q <= ram_rdata;
    end
    if (state == S_SUM) begin
      slot_q <= slot_pick;
    end
    if (out_load) begin
      res.smoothed_depth <= mean_out;
      // upper slots belong to the previous row, left slots to the previous column
      if (slot_q == SLOT_UPPER_LEFT || slot_q == SLOT_UPPER_EDGE) begin
        res.out_row <= ROW_W'(r_q - RW'(1));
      end else begin
        res.out_row <= ROW_W'(r_q);
      end
      if (slot_q == SLOT_UPPER_LEFT || slot_q == SLOT_LOWER_LEFT) begin
        res.out_col <= COL_W'(c_q - CW'(1));
      end else begin
        res.out_col <= COL_W'(c_q);
      end
      res.last_of_item <= (mask_rest == '0);
      res.end_of_frame <= (slot_q == SLOT_LOWER_EDGE);
    end
  end

  // a result is only loaded for a slot that is still pending
  a_slot_pending: assert property (@(posedge clk) disable iff (rst)
    out_load |-> slot_mask[slot_q])
    else $error("result loaded for a slot that is not pending");

  // the bottom-right pixel is always the last result of its item
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (!res.end_of_frame || res.last_of_item))
    else $error("end of frame without last of item");

  // an item without results goes from the read state straight back to idle and frees the input
  a_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ && slot_mask == '0) |=> pix.ready)
    else $error("empty item did not return to idle");

  // the output register is never overwritten while holding an untaken result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> $stable(res.smoothed_depth))
    else $error("pending result overwritten");

endmodule

/* sv/dhas_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module dhas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/dhas_mean.sv */
// mean of the nonzero values among four depth samples, sum registered before the divide
`timescale 1ns / 1ps

module dhas_mean (
  input  logic                          clk,
  input  logic                          load,
  input  dhas_pkg::depth_t [3:0]        vals,
  output dhas_pkg::depth_t              mean
);
  import dhas_pkg::*;

  logic [SUM_W-1:0]  sum_c;
  logic [CNT_W-1:0]  cnt_c;
  logic [SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  quot;

  always_comb begin
    sum_c = '0;
    cnt_c = '0;
    for (int k = 0; k < 4; k++) begin
      if (vals[k] != '0) begin
        sum_c = sum_c + SUM_W'(vals[k]);
        cnt_c = cnt_c + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_q <= sum_c;
      cnt_q <= cnt_c;
    end
  end

  // divide by the count: shifts for 1, 2, 4 and a reciprocal multiply for 3
  assign prod = PROD_W'(sum_q) * PROD_W'(DIV3_MULT);

  always_comb begin
    unique case (cnt_q)
      CNT_W'(1): quot = sum_q;
      CNT_W'(2): quot = sum_q >> 1;
      CNT_W'(3): quot = SUM_W'(prod >> DIV3_SHIFT);
      CNT_W'(4): quot = sum_q >> 2;
      default:   quot = '0;
    endcase
  end

  assign mean = quot[DEPTH_W-1:0];

endmodule
